[sv/ids_pkg.sv]
package ids_pkg;

  localparam int MAX_POINTS_DEF = 512;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 61;

  localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FSCALE = 2'd2;

  localparam logic [31:0] LAMBDA_RST = 32'd8388608;
  localparam logic [9:0] POINTS_RST = 10'd268;
  localparam logic [31:0] FSCALE_RST = 32'd1638400;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [17:0] {
    ST_CLEAR   = 18'h00001,
    ST_IDLE    = 18'h00002,
    ST_SETUP   = 18'h00004,
    ST_SETLAST = 18'h00008,
    ST_G0      = 18'h00010,
    ST_G1      = 18'h00020,
    ST_GDIV    = 18'h00040,
    ST_G2      = 18'h00080,
    ST_G3      = 18'h00100,
    ST_F0      = 18'h00200,
    ST_F1      = 18'h00400,
    ST_F2      = 18'h00800,
    ST_B0      = 18'h01000,
    ST_B1      = 18'h02000,
    ST_B2      = 18'h04000,
    ST_X0      = 18'h08000,
    ST_X1      = 18'h10000,
    ST_X2      = 18'h20000
  } state_t;

endpackage

[sv/implicit_diffusion_thomas_step.sv]
// channel   direction  handshake                 payload
// surf      in         surf_valid / surf_stall   surface_conc
// res       out        res_valid / res_stall     flux, surface_echo
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// the forward sweep takes each node through F0, F1, F2 and the back sweep
// through B0, B1, B2, each with a profile memory access; when coefficients
// are stale, each node first passes through G0, G1, the bit-serial
// reciprocal divider GDIV, then G2 and G3
// after reset a clearing pass loads 1.0 into every profile entry while
// surf_stall is high; cfg writes are taken at any time
module implicit_diffusion_thomas_step #(
  parameter int MAX_POINTS = ids_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          surf_valid,
  output logic                          surf_stall,
  input  logic [30:0]                   surface_conc,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [31:0]            flux,
  output logic [30:0]                   surface_echo,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ids_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);

  ids_pkg::state_t state;

  logic [31:0]   lambda_coeff;
  logic [9:0]    points_in_use;
  logic [31:0]   flux_scale;
  logic          coeffs_ready;

  logic [AW-1:0] idx;
  logic [AW-1:0] nm1;
  logic [30:0]   surf;
  logic [30:0]   gprev;
  logic [63:0]   prod;
  logic [39:0]   pivot;
  logic [40:0]   rem;
  logic [60:0]   dnum;
  logic [30:0]   quo;
  logic [5:0]    dcnt;
  logic [31:0]   cprev;
  logic [31:0]   cnext;
  logic [31:0]   c2;
  logic [10:0]   nhi;
  logic [33:0]   mag;
  logic          neg_sign;

  logic          prof_we;
  logic [AW-1:0] prof_waddr;
  logic [31:0]   prof_wdata;
  logic [31:0]   prof_rd;
  logic          coef_we;
  logic [61:0]   coef_rd;

  logic [31:0]   n_eff;
  logic [40:0]   rem_sh;
  logic [30:0]   gm_next;
  logic [39:0]   gm_round;
  logic [40:0]   num;
  logic [42:0]   fwd_sum;
  logic [31:0]   fwd_res;
  logic [33:0]   bk_sum;
  logic [31:0]   bk_res;
  logic [33:0]   pos;
  logic [33:0]   negv;
  logic [36:0]   fmag;
  logic [31:0]   flux_next;
  logic          out_free;

  function automatic logic [39:0] pivot_half(input logic [39:0] p);
    pivot_half = p >> 1;
  endfunction

  ids_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_prof (
    .clk   (clk),
    .we    (prof_we),
    .waddr (prof_waddr),
    .wdata (prof_wdata),
    .raddr (idx),
    .rdata (prof_rd)
  );

  ids_ram #(.WIDTH(62), .DEPTH(MAX_POINTS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (idx),
    .wdata ({gm_next, quo}),
    .raddr (idx),
    .rdata (coef_rd)
  );

  assign surf_stall = (state != ids_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    n_eff = {22'd0, points_in_use};
    if (n_eff < 32'd3) begin
      n_eff = 32'd3;
    end else if (n_eff > 32'(MAX_POINTS)) begin
      n_eff = 32'(MAX_POINTS);
    end
    rem_sh   = {rem[39:0], dnum[60]};
    gm_round = 40'((prod + 64'd8388608) >> 24);
    gm_next  = (gm_round > 40'(ids_pkg::ONE_Q30)) ? ids_pkg::ONE_Q30[30:0] : gm_round[30:0];
    num      = 41'(prof_rd) + 41'(prod[63:24]);
    fwd_sum  = 43'(nhi * coef_rd[30:0]) + 43'((prod + 64'h2000_0000) >> 30);
    fwd_res  = (fwd_sum > 43'hFFFF_FFFF) ? 32'hFFFF_FFFF : fwd_sum[31:0];
    bk_sum   = 34'(prof_rd) + 34'((prod + 64'h2000_0000) >> 30);
    bk_res   = (bk_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : bk_sum[31:0];
    pos      = 34'(3) * 34'(surf) + 34'(c2);
    negv     = {cnext, 2'b00};
    fmag     = 37'(mag[33:30] * flux_scale) + 37'((prod + 64'h2000_0000) >> 30);
    if (!neg_sign) begin
      flux_next = (fmag > 37'h7FFF_FFFF) ? 32'h7FFF_FFFF : fmag[31:0];
    end else begin
      flux_next = (fmag > 37'h8000_0000) ? 32'h8000_0000 : 32'(-fmag[31:0]);
    end
    prof_we    = 1'b0;
    prof_waddr = idx;
    prof_wdata = fwd_res;
    coef_we    = (state == ids_pkg::ST_G3);
    unique case (state)
      ids_pkg::ST_CLEAR: begin
        prof_we    = 1'b1;
        prof_wdata = ids_pkg::ONE_Q30;
      end
      ids_pkg::ST_SETUP: begin
        prof_we    = 1'b1;
        prof_waddr = '0;
        prof_wdata = {1'b0, surf};
      end
      ids_pkg::ST_SETLAST: begin
        prof_we    = 1'b1;
        prof_waddr = nm1;
        prof_wdata = ids_pkg::ONE_Q30;
      end
      ids_pkg::ST_F2: begin
        prof_we = 1'b1;
      end
      ids_pkg::ST_B2: begin
        prof_we    = 1'b1;
        prof_wdata = bk_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ids_pkg::ST_CLEAR;
      idx           <= '0;
      lambda_coeff  <= ids_pkg::LAMBDA_RST;
      points_in_use <= ids_pkg::POINTS_RST;
      flux_scale    <= ids_pkg::FSCALE_RST;
      coeffs_ready  <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ids_pkg::REG_LAMBDA: begin
            lambda_coeff <= cfg_data;
            coeffs_ready <= 1'b0;
          end
          ids_pkg::REG_POINTS: begin
            points_in_use <= cfg_data[9:0];
            coeffs_ready  <= 1'b0;
          end
          ids_pkg::REG_FSCALE: begin
            flux_scale   <= cfg_data;
            coeffs_ready <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      unique case (state)
        ids_pkg::ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == AW'(MAX_POINTS - 1)) begin
            state <= ids_pkg::ST_IDLE;
          end
        end
        ids_pkg::ST_IDLE: begin
          if (surf_valid) begin
            surf  <= surface_conc;
            nm1   <= AW'(n_eff - 32'd1);
            state <= ids_pkg::ST_SETUP;
          end
        end
        ids_pkg::ST_SETUP: begin
          state <= ids_pkg::ST_SETLAST;
        end
        ids_pkg::ST_SETLAST: begin
          idx   <= AW'(1);
          gprev <= '0;
          cprev <= {1'b0, surf};
          state <= coeffs_ready ? ids_pkg::ST_F0 : ids_pkg::ST_G0;
        end
        ids_pkg::ST_G0: begin
          prod  <= 64'(lambda_coeff * gprev);
          state <= ids_pkg::ST_G1;
        end
        ids_pkg::ST_G1: begin
          pivot <= 40'(ids_pkg::ONE_Q30) + {1'b0, lambda_coeff, 7'd0} - 40'(prod[63:24]);
          dnum  <= {1'b1, 60'd0} + 61'(pivot_half(
                     40'(ids_pkg::ONE_Q30) + {1'b0, lambda_coeff, 7'd0} - 40'(prod[63:24])));
          rem   <= '0;
          dcnt  <= '0;
          state <= ids_pkg::ST_GDIV;
        end
        ids_pkg::ST_GDIV: begin
          dnum <= {dnum[59:0], 1'b0};
          if (rem_sh >= 41'(pivot)) begin
            rem <= rem_sh - 41'(pivot);
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[29:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'(ids_pkg::DIV_STEPS - 1)) begin
            state <= ids_pkg::ST_G2;
          end
        end
        ids_pkg::ST_G2: begin
          prod  <= 64'(lambda_coeff * quo);
          state <= ids_pkg::ST_G3;
        end
        ids_pkg::ST_G3: begin
          gprev <= gm_next;
          if (idx == nm1 - 1'b1) begin
            coeffs_ready <= 1'b1;
            idx          <= AW'(1);
            state        <= ids_pkg::ST_F0;
          end else begin
            idx   <= idx + 1'b1;
            state <= ids_pkg::ST_G0;
          end
        end
        ids_pkg::ST_F0: begin
          prod  <= 64'(lambda_coeff * cprev);
          state <= ids_pkg::ST_F1;
        end
        ids_pkg::ST_F1: begin
          prod  <= 64'(num[29:0] * coef_rd[30:0]);
          nhi   <= num[40:30];
          state <= ids_pkg::ST_F2;
        end
        ids_pkg::ST_F2: begin
          cprev <= fwd_res;
          if (idx == nm1 - 1'b1) begin
            cnext <= ids_pkg::ONE_Q30;
            state <= ids_pkg::ST_B0;
          end else begin
            idx   <= idx + 1'b1;
            state <= ids_pkg::ST_F0;
          end
        end
        ids_pkg::ST_B0: begin
          state <= ids_pkg::ST_B1;
        end
        ids_pkg::ST_B1: begin
          prod  <= 64'(coef_rd[61:31] * cnext);
          state <= ids_pkg::ST_B2;
        end
        ids_pkg::ST_B2: begin
          c2    <= cnext;
          cnext <= bk_res;
          if (idx == AW'(1)) begin
            state <= ids_pkg::ST_X0;
          end else begin
            idx   <= idx - 1'b1;
            state <= ids_pkg::ST_B0;
          end
        end
        ids_pkg::ST_X0: begin
          neg_sign <= (pos < negv);
          mag      <= (pos >= negv) ? pos - negv : negv - pos;
          state    <= ids_pkg::ST_X1;
        end
        ids_pkg::ST_X1: begin
          prod  <= 64'(mag[29:0] * flux_scale);
          state <= ids_pkg::ST_X2;
        end
        ids_pkg::ST_X2: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            flux         <= flux_next;
            surface_echo <= surf;
            state        <= ids_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ids_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ids_ram.sv]
module ids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
